@@ sv/csfw_pkg.sv @@
// ----------------------------------------------------------------------------
// csfw_pkg
// Shared types and constants for the counting semaphore with FIFO wait queue.
// ----------------------------------------------------------------------------
package csfw_pkg;

   // Default sizes for the top-level parameters
   localparam int QUEUE_SLOTS_DEF  = 8;
   localparam int TASK_ID_BITS_DEF = 4;

   // Fixed field widths
   localparam int COUNT_W  = 16;
   localparam int INIT_W   = 15;
   localparam int STATUS_W = 3;

   localparam logic signed [COUNT_W-1:0] COUNT_MAX  = 16'sd32767;
   localparam logic signed [COUNT_W-1:0] COUNT_ONE  = 16'sd1;
   localparam logic signed [COUNT_W-1:0] COUNT_ZERO = 16'sd0;
   localparam logic [INIT_W-1:0]         INIT_RESET = 15'd1;

   // Request opcodes
   localparam logic OP_WAIT = 1'b0;
   localparam logic OP_POST = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_ACQUIRED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BLOCKED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_REFUSED  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_WOKE     = 3'd4;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the incoming request
      logic execute;   // update count, queue pointers and queue memory
   } csfw_cmd_type;

endpackage

@@ sv/counting_semaphore_fifo_waitq.sv @@
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waitq
// Counting semaphore with a FIFO queue of blocked task ids.
// ----------------------------------------------------------------------------
//  channel    | handshake            | payload
//  -----------+----------------------+------------------------------------------
//  request    | start / busy         | req_opcode, req_task_id
//  response   | rsp_valid (strobe)   | rsp_status, rsp_yield_request,
//             |                      | rsp_wake_valid, rsp_wake_task
//  csr        | csr_wr_en            | csr_wr_data (initial count)
//
//  Each request passes through accept, execute (count and pointer update,
//  queue write, head read) and response; the next request is
//  accepted in the cycle after the response. The registered read of the queue
//  memory sets the execute-to-response step. Synchronous reset loads a count
//  of 1 and empties the queue. The receiver cannot stall; rsp_valid is a
//  single-cycle strobe.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_waitq #(
   parameter int QUEUE_SLOTS  = csfw_pkg::QUEUE_SLOTS_DEF,
   parameter int TASK_ID_BITS = csfw_pkg::TASK_ID_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_opcode,
   input  logic [TASK_ID_BITS-1:0]       req_task_id,
   output logic                          rsp_valid,
   output logic [csfw_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_yield_request,
   output logic                          rsp_wake_valid,
   output logic [TASK_ID_BITS-1:0]       rsp_wake_task,
   input  logic                          csr_wr_en,
   input  logic [csfw_pkg::INIT_W-1:0]   csr_wr_data
);

   csfw_pkg::csfw_cmd_type cmd;

   // sequencer
   csfw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // count, queue and response datapath
   csfw_dpath #(
      .QUEUE_SLOTS  (QUEUE_SLOTS),
      .TASK_ID_BITS (TASK_ID_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_opcode        (req_opcode),
      .req_task_id       (req_task_id),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_status        (rsp_status),
      .rsp_yield_request (rsp_yield_request),
      .rsp_wake_valid    (rsp_wake_valid),
      .rsp_wake_task     (rsp_wake_task)
   );

endmodule

@@ sv/csfw_ram.sv @@
// ----------------------------------------------------------------------------
// csfw_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module csfw_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/csfw_ctrl.sv @@
// ----------------------------------------------------------------------------
// csfw_ctrl
// Sequencer: accept a request, execute it, present the response for one cycle.
// ----------------------------------------------------------------------------
module csfw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_valid,
   output csfw_pkg::csfw_cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_EXEC;
         end
         S_EXEC:  state_in = S_RESP;
         S_RESP:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // outputs
   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = (state_ff == S_RESP);
   assign cmd.capture = (state_ff == S_IDLE) && start;
   assign cmd.execute = (state_ff == S_EXEC);

endmodule

@@ sv/csfw_dpath.sv @@
// ----------------------------------------------------------------------------
// csfw_dpath
// Datapath: resource count, wait queue pointers and memory, response fields.
// ----------------------------------------------------------------------------
module csfw_dpath #(
   parameter int QUEUE_SLOTS  = csfw_pkg::QUEUE_SLOTS_DEF,
   parameter int TASK_ID_BITS = csfw_pkg::TASK_ID_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  csfw_pkg::csfw_cmd_type          cmd,
   input  logic                            req_opcode,
   input  logic [TASK_ID_BITS-1:0]         req_task_id,
   input  logic                            csr_wr_en,
   input  logic [csfw_pkg::INIT_W-1:0]     csr_wr_data,
   output logic [csfw_pkg::STATUS_W-1:0]   rsp_status,
   output logic                            rsp_yield_request,
   output logic                            rsp_wake_valid,
   output logic [TASK_ID_BITS-1:0]         rsp_wake_task
);

   localparam int PTR_W = $clog2(QUEUE_SLOTS);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_SLOTS - 1);

   // request capture
   logic                    op_ff;
   logic [TASK_ID_BITS-1:0] task_ff;

   // semaphore state
   logic signed [csfw_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0]                    head_ff, head_in;
   logic [PTR_W-1:0]                    tail_ff, tail_in;

   // response fields
   logic [csfw_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                          yield_ff, yield_in;
   logic                          wake_ff, wake_in;

   // decision terms
   logic signed [csfw_pkg::COUNT_W-1:0] count_dec, count_inc;
   logic [PTR_W-1:0]                    tail_next, head_next;
   logic                                q_full, q_empty;
   logic                                can_acquire, woke;
   logic                                q_wr_en;
   logic [TASK_ID_BITS-1:0]             q_rd_data;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_opcode;
         task_ff <= req_task_id;
      end
   end

   // counter arithmetic and ring pointer steps
   assign count_dec   = count_ff - csfw_pkg::COUNT_ONE;
   assign count_inc   = (count_ff < csfw_pkg::COUNT_MAX) ? count_ff + csfw_pkg::COUNT_ONE
                                                         : count_ff;
   assign tail_next   = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
   assign head_next   = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
   assign q_full      = (tail_next == head_ff);
   assign q_empty     = (head_ff == tail_ff);
   assign can_acquire = (count_ff > csfw_pkg::COUNT_ZERO);
   assign woke        = (count_inc <= csfw_pkg::COUNT_ZERO) && !q_empty;

   // operation decode
   always_comb begin
      count_in  = count_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      status_in = status_ff;
      yield_in  = yield_ff;
      wake_in   = wake_ff;
      q_wr_en   = 1'b0;
      if (csr_wr_en) begin
         // reload: new count, queue emptied
         count_in = signed'({1'b0, csr_wr_data});
         head_in  = '0;
         tail_in  = '0;
      end else if (cmd.execute) begin
         yield_in = 1'b0;
         wake_in  = 1'b0;
         if (op_ff == csfw_pkg::OP_WAIT) begin
            if (can_acquire) begin
               count_in  = count_dec;
               status_in = csfw_pkg::ST_ACQUIRED;
            end else if (q_full) begin
               status_in = csfw_pkg::ST_REFUSED;
            end else begin
               count_in  = count_dec;
               tail_in   = tail_next;
               q_wr_en   = 1'b1;
               status_in = csfw_pkg::ST_BLOCKED;
               yield_in  = 1'b1;
            end
         end else begin
            count_in  = count_inc;
            status_in = csfw_pkg::ST_RELEASED;
            if (woke) begin
               head_in   = head_next;
               status_in = csfw_pkg::ST_WOKE;
               wake_in   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= signed'({1'b0, csfw_pkg::INIT_RESET});
         head_ff  <= '0;
         tail_ff  <= '0;
      end else begin
         count_ff <= count_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      yield_ff  <= yield_in;
      wake_ff   <= wake_in;
   end

   // wait queue storage; the head entry is read during execute
   csfw_ram #(
      .WIDTH (TASK_ID_BITS),
      .DEPTH (QUEUE_SLOTS)
   ) u_queue (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (tail_ff),
      .wr_data (task_ff),
      .rd_addr (head_ff),
      .rd_data (q_rd_data)
   );

   // response outputs
   assign rsp_status        = status_ff;
   assign rsp_yield_request = yield_ff;
   assign rsp_wake_valid    = wake_ff;
   assign rsp_wake_task     = wake_ff ? q_rd_data : '0;

endmodule
